/* hw/rtl/fplw_pkg.sv */
`timescale 1ns / 1ps

package fplw_pkg;

    localparam int FRAME_COUNT_DEFAULT = 64;

    localparam int LEVELS    = 5;
    localparam int INDEX_W   = 9;
    localparam int VPN_W     = 45;
    localparam int FRAME_W   = 52;
    localparam int KIND_W    = 2;
    localparam int ROOT_W    = 6;
    localparam int FFREE_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 7;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 56;

    localparam logic [FFREE_W-1:0] FFREE_RESET = 7'd1;
    localparam logic [ROOT_W-1:0]  ROOT_RESET  = 6'd0;

    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNMAP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd1;

    typedef logic [FRAME_W-1:0] frame_t;

    // one table entry: only the valid bit and the frame field are ever nonzero
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               valid;
    } entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VPN_W-1:0]   virtual_page;
        logic [FRAME_W-1:0] target_frame;
    } item_t;

    typedef struct packed {
        logic               mapped;
        logic [FRAME_W-1:0] found_frame;
        logic               status;
    } result_t;

endpackage

/* hw/rtl/fplw_store.sv */
`timescale 1ns / 1ps

module fplw_store #(
    parameter int FRAME_COUNT = fplw_pkg::FRAME_COUNT_DEFAULT
) (
    input  logic                                             aclk,
    input  logic                                             mem_we,
    input  logic                                             mem_re,
    input  logic [$clog2(FRAME_COUNT)+fplw_pkg::INDEX_W-1:0] mem_addr,
    input  fplw_pkg::entry_t                                 mem_wdata,
    output fplw_pkg::entry_t                                 mem_rdata
);

    localparam int DEPTH = FRAME_COUNT * (2 ** fplw_pkg::INDEX_W);

    fplw_pkg::entry_t mem_array [DEPTH];
    fplw_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem_array[mem_addr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

/* hw/rtl/fplw_walker.sv */
`timescale 1ns / 1ps

module fplw_walker #(
    parameter int FRAME_COUNT = fplw_pkg::FRAME_COUNT_DEFAULT
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  fplw_pkg::item_t                                  in_item,
    input  logic [fplw_pkg::ROOT_W-1:0]                      root_frame,
    input  logic                                             ffree_load,
    input  logic [fplw_pkg::FFREE_W-1:0]                     ffree_value,
    output logic                                             res_valid,
    input  logic                                             res_ready,
    output fplw_pkg::result_t                                res,
    output logic                                             mem_we,
    output logic                                             mem_re,
    output logic [$clog2(FRAME_COUNT)+fplw_pkg::INDEX_W-1:0] mem_addr,
    output fplw_pkg::entry_t                                 mem_wdata,
    input  fplw_pkg::entry_t                                 mem_rdata
);

    localparam int FA_W   = $clog2(FRAME_COUNT);
    localparam int ADDR_W = FA_W + fplw_pkg::INDEX_W;
    localparam int DEPTH  = FRAME_COUNT * (2 ** fplw_pkg::INDEX_W);
    localparam int NF_W   = ($clog2(FRAME_COUNT + 1) > fplw_pkg::FFREE_W) ?
                            $clog2(FRAME_COUNT + 1) : fplw_pkg::FFREE_W;
    localparam logic [2:0] LEAF_LEVEL = 3'(fplw_pkg::LEVELS - 1);
    localparam logic [fplw_pkg::INDEX_W-1:0] LAST_IDX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR_ALL,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CLR_FRAME,
        ST_LINK,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [ADDR_W-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [NF_W-1:0]                 next_free_reg, next_free_next;
    logic [2:0]                      lvl_reg, lvl_next;
    logic [fplw_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [fplw_pkg::VPN_W-1:0]      vpn_reg, vpn_next;
    fplw_pkg::frame_t                target_reg, target_next;
    fplw_pkg::frame_t                frame_reg, frame_next;
    fplw_pkg::result_t               result_reg, result_next;

    logic [fplw_pkg::INDEX_W-1:0]    level_idx;
    logic                            frame_oob;
    logic                            entry_ok;
    logic [FA_W-1:0]                 nf_addr;
    fplw_pkg::frame_t                nf_frame;

    always_comb begin
        case (lvl_reg)
            3'd0:    level_idx = vpn_reg[44:36];
            3'd1:    level_idx = vpn_reg[35:27];
            3'd2:    level_idx = vpn_reg[26:18];
            3'd3:    level_idx = vpn_reg[17:9];
            default: level_idx = vpn_reg[8:0];
        endcase
    end

    // tables outside the store read as zero and swallow writes
    assign frame_oob = frame_reg >= fplw_pkg::frame_t'(FRAME_COUNT);
    assign entry_ok  = mem_rdata.valid && !frame_oob;
    assign nf_addr   = next_free_reg[FA_W-1:0];
    assign nf_frame  = fplw_pkg::frame_t'(next_free_reg);

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        next_free_next = next_free_reg;
        lvl_next       = lvl_reg;
        kind_next      = kind_reg;
        vpn_next       = vpn_reg;
        target_next    = target_reg;
        frame_next     = frame_reg;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = {frame_reg[FA_W-1:0], level_idx};
        mem_wdata      = '0;

        case (state_reg)
            ST_CLEAR_ALL: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    kind_next   = in_item.kind;
                    vpn_next    = in_item.virtual_page;
                    target_next = in_item.target_frame;
                    frame_next  = fplw_pkg::frame_t'(root_frame);
                    lvl_next    = '0;
                    result_next = '0;
                    if (in_item.kind == fplw_pkg::KIND_QUERY ||
                        in_item.kind == fplw_pkg::KIND_MAP ||
                        in_item.kind == fplw_pkg::KIND_UNMAP) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                if (kind_reg != fplw_pkg::KIND_QUERY && lvl_reg == LEAF_LEVEL) begin
                    // leaf of an update: write without reading
                    mem_we = !frame_oob;
                    if (kind_reg == fplw_pkg::KIND_MAP) begin
                        mem_wdata.frame = target_reg;
                        mem_wdata.valid = 1'b1;
                    end
                    state_next = ST_DONE;
                end else begin
                    mem_re     = !frame_oob;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (kind_reg == fplw_pkg::KIND_QUERY) begin
                    if (!entry_ok) begin
                        state_next = ST_DONE;
                    end else if (lvl_reg == LEAF_LEVEL) begin
                        result_next.mapped      = 1'b1;
                        result_next.found_frame = mem_rdata.frame;
                        state_next              = ST_DONE;
                    end else begin
                        frame_next = mem_rdata.frame;
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end else if (entry_ok) begin
                    frame_next = mem_rdata.frame;
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = ST_READ;
                end else if (kind_reg == fplw_pkg::KIND_UNMAP) begin
                    state_next = ST_DONE;
                end else if (next_free_reg >= NF_W'(FRAME_COUNT)) begin
                    result_next.status = 1'b1;
                    state_next         = ST_DONE;
                end else begin
                    state_next = ST_CLR_FRAME;
                end
            end
            ST_CLR_FRAME: begin
                // wipe the new table before linking, the parent may live in it
                mem_we       = 1'b1;
                mem_addr     = {nf_addr, clr_cnt_reg[fplw_pkg::INDEX_W-1:0]};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg[fplw_pkg::INDEX_W-1:0] == LAST_IDX) begin
                    clr_cnt_next = '0;
                    state_next   = ST_LINK;
                end
            end
            ST_LINK: begin
                mem_we          = !frame_oob;
                mem_wdata.frame = nf_frame;
                mem_wdata.valid = 1'b1;
                frame_next      = nf_frame;
                lvl_next        = lvl_reg + 1'b1;
                next_free_next  = next_free_reg + 1'b1;
                state_next      = ST_READ;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (ffree_load) begin
            next_free_next = NF_W'(ffree_value);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR_ALL;
            clr_cnt_reg   <= '0;
            next_free_reg <= NF_W'(fplw_pkg::FFREE_RESET);
            lvl_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            next_free_reg <= next_free_next;
            lvl_reg       <= lvl_next;
            kind_reg      <= kind_next;
            vpn_reg       <= vpn_next;
            target_reg    <= target_next;
            frame_reg     <= frame_next;
            result_reg    <= result_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = result_reg;

endmodule

/* hw/rtl/five_level_page_table_walker_top.sv */
`timescale 1ns / 1ps

// Five-level radix page-table walker over an internal table store of FRAME_COUNT
// frames of 512 entries, one request (query, map, unmap) in flight at a time.
// Every table level of a query costs one store read plus an evaluation; a map
// or unmap that finds its path in place walks four intermediate levels, then
// writes the leaf without a read, and every result is then handed to the output
// register. Each table a map has to allocate is wiped by the single store
// port, one entry per cycle, and then linked. After reset the whole store is
// cleared, one entry a cycle, while s_tready stays low; configuration writes
// are taken throughout. The result register lets the next request enter while
// a result waits on m_tready.
module five_level_page_table_walker_top #(
    parameter int FRAME_COUNT = fplw_pkg::FRAME_COUNT_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // virtual_page[44:0], target_frame[96:45], zero pad
    input  logic [fplw_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [fplw_pkg::KIND_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // found_frame[51:0], zero pad
    output logic [fplw_pkg::M_TDATA_W-1:0]   m_tdata,
    // mapped[0], status[1]
    output logic [1:0]                       m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [fplw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fplw_pkg::CFG_DW-1:0]      cfg_wr_data
);

    localparam int ADDR_W = $clog2(FRAME_COUNT) + fplw_pkg::INDEX_W;

    logic [fplw_pkg::ROOT_W-1:0] root_frame_reg;
    logic                        m_tvalid_reg;
    fplw_pkg::result_t           out_reg;

    fplw_pkg::item_t             in_item;
    fplw_pkg::result_t           res;
    logic                        res_valid;
    logic                        res_ready;
    logic                        ffree_load;

    logic                        mem_we;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_addr;
    fplw_pkg::entry_t            mem_wdata;
    fplw_pkg::entry_t            mem_rdata;

    assign in_item.kind         = s_tuser;
    assign in_item.virtual_page = s_tdata[44:0];
    assign in_item.target_frame = s_tdata[96:45];

    assign ffree_load = cfg_wr_en && (cfg_index == fplw_pkg::CFG_FIRST_FREE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_frame_reg <= fplw_pkg::ROOT_RESET;
        end else if (cfg_wr_en && cfg_index == fplw_pkg::CFG_ROOT_FRAME) begin
            root_frame_reg <= cfg_wr_data[fplw_pkg::ROOT_W-1:0];
        end
    end

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
            if (res_valid) begin
                out_reg <= res;
            end
        end
    end

    fplw_walker #(
        .FRAME_COUNT(FRAME_COUNT)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .root_frame (root_frame_reg),
        .ffree_load (ffree_load),
        .ffree_value(cfg_wr_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_re     (mem_re),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    fplw_store #(
        .FRAME_COUNT(FRAME_COUNT)
    ) u_store (
        .aclk     (aclk),
        .mem_we   (mem_we),
        .mem_re   (mem_re),
        .mem_addr (mem_addr),
        .mem_wdata(mem_wdata),
        .mem_rdata(mem_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_reg.found_frame};
    assign m_tuser  = {out_reg.status, out_reg.mapped};

endmodule

/* hw/rtl/fplw_checker.sv */
`timescale 1ns / 1ps

module fplw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fplw_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser
);

    // no result beat survives a reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // a failed map never reports a mapping
    a_status_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("status and mapped both set");

    a_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("frame nonzero without a mapping");

    // one request at a time: an accepted beat closes the input
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input reopened right after a beat");

endmodule

bind five_level_page_table_walker_top fplw_checker u_checker (.*);
